// ----- hw/rtl/mavsd_pkg.sv -----
// ============================================================================
// Moving-average settle detector package
// Shared sample width, register width and controller state encoding.
// ============================================================================
package mavsd_pkg;

    // Width of one signed sample and of the mean.
    localparam int unsigned SAMPLE_W = 16;

    // Width of the settle limit register.
    localparam int unsigned LIMIT_W = 16;

    // Controller states for one transaction.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CALC,
        ST_MEAN,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/moving_average_settle_detect.sv -----
// ============================================================================
// Moving-average filter with settle detection
// Keeps a circular window of the last WINDOW_LEN samples and a running sum,
// returns the truncated mean of the filled entries, and flags when the
// window is full and both extremes lie within settle_limit of the mean.
// ============================================================================
//
//  Channel   Signals                          Direction  Payload
//  -------   ------------------------------   ---------  --------------------
//  in        in_valid / in_ready              input      sample (s16)
//  out       out_valid / out_ready            output     mean (s16), settled
//  cfg       cfg_wr_en                        input      cfg_wr_data (u16)
//
//  The bit-serial restoring divider, one quotient bit per cycle, runs in
//  ST_CALC beside the min/max scan, which reads one entry per cycle
//  through the single window memory read port once the window is full;
//  the later of the two to finish sets when the result is formed. A new
//  sample is only accepted after the previous result has been loaded.
//  Reset (rst_n low, asynchronous) empties the window and clears the sum.
//  A finished result waits in the output register while the next sample
//  is accepted; only a second result stalls on out_ready.
//
module moving_average_settle_detect
    import mavsd_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] mean,
    output logic                       settled,
    input  logic                       cfg_wr_en,
    input  logic        [LIMIT_W-1:0]  cfg_wr_data
);

    localparam int unsigned PTR_W  = $clog2(WINDOW_LEN);
    localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int unsigned SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int unsigned DCNT_W = $clog2(SUM_W + 1);
    localparam int unsigned CMP_W  = SAMPLE_W + 2;

    localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW_LEN);
    localparam logic [PTR_W-1:0]  WIN_LAST = PTR_W'(WINDOW_LEN - 1);
    localparam logic [DCNT_W-1:0] DIV_LEN  = DCNT_W'(SUM_W);

    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // Controller and window state.
    state_t                      state_reg, state_next;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic signed [SAMPLE_W-1:0]  window_mem [WINDOW_LEN];
    logic signed [SAMPLE_W-1:0]  rd_data_reg;
    logic        [CNT_W-1:0]     fill_cnt_reg;
    logic        [PTR_W-1:0]     wr_ptr_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic        [LIMIT_W-1:0]   settle_limit_reg;

    // Serial divider and window scanner.
    logic        [SUM_W-1:0]     div_reg;
    logic        [CNT_W-1:0]     rem_reg;
    logic        [DCNT_W-1:0]    div_cnt_reg;
    logic                        neg_reg;
    logic        [CNT_W-1:0]     scan_addr_reg;
    logic                        scan_vld_reg;
    logic signed [SAMPLE_W-1:0]  max_reg;
    logic signed [SAMPLE_W-1:0]  min_reg;
    logic signed [SAMPLE_W-1:0]  avg_reg;

    // Output register.
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  mean_reg;
    logic                        settled_reg;

    // Decoded control.
    logic                        in_fire;
    logic                        rd_en;
    logic        [PTR_W-1:0]     rd_addr;
    logic                        win_full;
    logic                        scan_issue;
    logic                        scan_done;
    logic                        calc_done;
    logic                        out_slot_free;

    // Datapath intermediates.
    logic signed [SUM_W-1:0]     sample_ext;
    logic signed [SUM_W-1:0]     evict_ext;
    logic signed [SUM_W-1:0]     sum_next;
    logic        [SUM_W-1:0]     sum_mag;
    logic        [CNT_W:0]       trial;
    logic                        q_bit;
    logic        [CNT_W-1:0]     rem_next;
    logic signed [CMP_W-1:0]     spread_hi;
    logic signed [CMP_W-1:0]     spread_lo;
    logic signed [CMP_W-1:0]     limit_ext;
    logic                        settled_next;

    assign win_full      = (fill_cnt_reg == WIN_CNT);
    assign scan_issue    = win_full && (scan_addr_reg != WIN_CNT);
    assign scan_done     = (!win_full || (scan_addr_reg == WIN_CNT)) && !scan_vld_reg;
    assign calc_done     = (div_cnt_reg == '0) && scan_done;
    assign out_slot_free = !out_valid_reg || out_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_CALC;
            ST_CALC:   if (calc_done) state_next = ST_MEAN;
            ST_MEAN:   state_next = ST_DONE;
            ST_DONE:   if (out_slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = scan_addr_reg[PTR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = wr_ptr_reg;
            end
            ST_CALC:
            begin
                rd_en = scan_issue;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_limit_reg <= '0;
        else if (cfg_wr_en)
            settle_limit_reg <= cfg_wr_data;
    end

    // Sample capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_reg <= sample;
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
            window_mem[wr_ptr_reg] <= sample_reg;
        if (rd_en)
            rd_data_reg <= window_mem[rd_addr];
    end

    // Running sum update; the evicted entry only counts once the window is full.
    assign sample_ext = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign evict_ext  = win_full
                      ? {{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg}
                      : '0;
    assign sum_next   = sum_reg + sample_ext - evict_ext;
    assign sum_mag    = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            wr_ptr_reg   <= '0;
            sum_reg      <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            sum_reg    <= sum_next;
            wr_ptr_reg <= (wr_ptr_reg == WIN_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (!win_full)
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
        end
    end

    // One restoring-division step: bring in the next dividend bit and
    // subtract the fill count when it fits.
    assign trial    = {rem_reg, div_reg[SUM_W-1]};
    assign q_bit    = (trial >= {1'b0, fill_cnt_reg});
    assign rem_next = q_bit ? CNT_W'(trial - {1'b0, fill_cnt_reg}) : trial[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (state_reg == ST_UPDATE)
            div_cnt_reg <= DIV_LEN;
        else if ((state_reg == ST_CALC) && (div_cnt_reg != '0))
            div_cnt_reg <= div_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            div_reg <= sum_mag;
            rem_reg <= '0;
            neg_reg <= sum_next[SUM_W-1];
        end
        else if ((state_reg == ST_CALC) && (div_cnt_reg != '0))
        begin
            div_reg <= {div_reg[SUM_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    // Window scan for the extremes, one entry per cycle behind the read port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            scan_vld_reg  <= 1'b0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            scan_addr_reg <= '0;
            scan_vld_reg  <= 1'b0;
        end
        else if (state_reg == ST_CALC)
        begin
            scan_vld_reg <= scan_issue;
            if (scan_issue)
                scan_addr_reg <= scan_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            max_reg <= S_MIN;
            min_reg <= S_MAX;
        end
        else if (scan_vld_reg)
        begin
            if (rd_data_reg > max_reg)
                max_reg <= rd_data_reg;
            if (rd_data_reg < min_reg)
                min_reg <= rd_data_reg;
        end
    end

    // Signed mean from the quotient magnitude; truncation is toward zero.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MEAN)
            avg_reg <= neg_reg ? -div_reg[SAMPLE_W-1:0] : div_reg[SAMPLE_W-1:0];
    end

    // Settle test against the configured limit.
    assign spread_hi    = CMP_W'(max_reg) - CMP_W'(avg_reg);
    assign spread_lo    = CMP_W'(avg_reg) - CMP_W'(min_reg);
    assign limit_ext    = {2'b00, settle_limit_reg};
    assign settled_next = win_full && (spread_hi <= limit_ext) && (spread_lo <= limit_ext);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == ST_DONE) && out_slot_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_slot_free)
        begin
            mean_reg    <= avg_reg;
            settled_reg <= settled_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;
    assign settled   = settled_reg;

endmodule

// ----- hw/rtl/mavsd_checker.sv -----
// ============================================================================
// Moving-average settle detector checker
// Port-level checks on handshake timing and result ordering.
// ============================================================================
module mavsd_checker
    import mavsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] mean,
    input  logic                       settled
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(mean) && $stable(settled)))
        else $error("result changed while stalled");

    // The block takes one sample at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second sample taken while busy");

    // A new result never appears directly after a sample is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared without computation time");

    // Loading a result frees the input side at the same edge.
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("input not ready after result was loaded");

    // A settled result always carries a known mean.
    a_settled_known: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && settled) |-> !$isunknown(mean))
        else $error("settled result carries unknown mean");

endmodule

bind moving_average_settle_detect mavsd_checker u_mavsd_checker (.*);

// ----- bench/tb_moving_average_settle_detect.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the moving-average settle detector
// Drives signed samples through valid/ready with random bursts and output
// stalls. A scoreboard keeps its own window and running sum, finds the extremes,
// predicts each mean and settled flag, and compares every output transaction
// in order. Runs cover several settle limits, including both extremes.
// ============================================================================
module tb_moving_average_settle_detect;
    import mavsd_pkg::*;

    localparam int unsigned WIN_LEN          = 8;
    localparam int          PHASE_SAMPLES    = 105;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          DRAIN_LIMIT      = 4000;

    // Clock, reset and block ports.
    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] mean;
    logic                       settled;
    logic                       cfg_wr_en;
    logic        [LIMIT_W-1:0]  cfg_wr_data;

    // One predicted output transaction.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic                       settled;
    } avg_result_t;

    // Scoreboard: models the window and holds the predicted averages in order.
    class settle_scoreboard;
        logic signed [SAMPLE_W-1:0] slots [WIN_LEN];
        int unsigned                depth_used;
        int unsigned                next_slot;
        int                         window_total;
        logic        [LIMIT_W-1:0]  limit;
        avg_result_t                predicted_avgs [$];
        int                         errors;
        int                         checked;
        int                         settled_seen;

        function new();
            depth_used   = 0;
            next_slot    = 0;
            window_total = 0;
            limit        = '0;
            errors       = 0;
            checked      = 0;
            settled_seen = 0;
        endfunction

        function int pending();
            return predicted_avgs.size();
        endfunction

        // Update the window with an accepted sample and queue the expected output.
        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            avg_result_t exp;
            int          quotient;
            int          hi;
            int          lo;

            if (depth_used == WIN_LEN) begin
                window_total += int'(s) - int'(slots[next_slot]);
            end
            else begin
                window_total += int'(s);
                depth_used++;
            end
            slots[next_slot] = s;
            next_slot = (next_slot + 1) % WIN_LEN;

            // Integer division truncates toward zero, as the block does.
            quotient = window_total / int'(depth_used);
            exp.mean = quotient[SAMPLE_W-1:0];
            exp.settled = 1'b0;

            // Settle check uses the true extremes over a full window.
            if (depth_used == WIN_LEN) begin
                hi = int'(slots[0]);
                lo = int'(slots[0]);
                for (int i = 1; i < WIN_LEN; i++) begin
                    if (int'(slots[i]) > hi) hi = int'(slots[i]);
                    if (int'(slots[i]) < lo) lo = int'(slots[i]);
                end
                if (hi - quotient <= int'(limit) && quotient - lo <= int'(limit))
                    exp.settled = 1'b1;
            end
            predicted_avgs.push_back(exp);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        // Compare one output transaction with the oldest prediction.
        task check_result(logic signed [SAMPLE_W-1:0] got_mean, logic got_settled);
            avg_result_t exp;

            if (predicted_avgs.size() == 0) begin
                report_mismatch($sformatf("unexpected result mean=%0d settled=%0b",
                                          got_mean, got_settled));
            end
            else begin
                exp = predicted_avgs.pop_front();
                checked++;
                if (got_settled === 1'b1) settled_seen++;
                if (got_mean !== exp.mean)
                    report_mismatch($sformatf("mean %0d, expected %0d", got_mean, exp.mean));
                if (got_settled !== exp.settled)
                    report_mismatch($sformatf("settled %0b, expected %0b (mean %0d)",
                                              got_settled, exp.settled, exp.mean));
            end
        endtask
    endclass

    settle_scoreboard sb = new();

    bit hold_request = 1'b0;
    int holds_done   = 0;
    int burst_left   = 0;
    int samples_sent = 0;
    int limits_used  = 0;

    moving_average_settle_detect #(
        .WINDOW_LEN (WIN_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mean        (mean),
        .settled     (settled),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output monitor: every accepted output transaction is checked.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(mean, settled);
    end

    // Output stall pattern, with an occasional long hold requested by the sender side.
    initial
    begin
        int mode;
        int seg_len;

        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request) begin
                hold_request = 1'b0;
                holds_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else begin
                mode    = $urandom_range(0, 3);
                seg_len = $urandom_range(10, 120);
                for (int k = 0; k < seg_len; k++) begin
                    if (hold_request) break;
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= (k % 5 == 0);
                        default: out_ready <= (k % 3 != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4_000_000;
        $display("Timeout: %0d results still expected", sb.pending());
        $display("tb_moving_average_settle_detect failed");
        $finish;
    end

    // Present one sample and hold it until the block takes it.
    task automatic offer_sample(logic signed [SAMPLE_W-1:0] value);
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_sample(value);
        samples_sent++;
    endtask

    // Drop valid for a number of cycles, with junk on the sample bus.
    task automatic idle_input(int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            sample   <= SAMPLE_W'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Send in bursts of random length separated by random gaps.
    task automatic paced_sample(logic signed [SAMPLE_W-1:0] value, bit no_gaps);
        if (burst_left == 0) begin
            if (!no_gaps)
                idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
            burst_left = $urandom_range(1, 12);
        end
        offer_sample(value);
        burst_left--;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Change the settle limit only while nothing is in flight.
    task automatic write_limit(logic [LIMIT_W-1:0] value);
        wait_for_drain();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.limit = value;
        limits_used++;
    endtask

    // One phase: steady segments with noise around the limit, spikes and steps.
    task automatic run_phase(logic [LIMIT_W-1:0] limit, bit long_hold);
        int base;
        int amp;
        int seg_left;
        int value;

        write_limit(limit);
        if (long_hold) hold_request = 1'b1;
        seg_left = 0;
        base = 0;
        amp = 0;
        for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if (seg_left == 0) begin
                base = int'($signed(SAMPLE_W'($urandom)));
                case ($urandom_range(0, 4))
                    0:       amp = 0;
                    1:       amp = int'(limit) / 2;
                    2:       amp = int'(limit);
                    3:       amp = 2 * int'(limit) + 1;
                    default: amp = $urandom_range(0, 16);
                endcase
                seg_left = $urandom_range(4, 24);
            end
            if ($urandom_range(0, 19) == 0)
                value = int'($signed(SAMPLE_W'($urandom)));
            else
                value = base + int'($urandom_range(0, 2 * amp)) - amp;
            if (value > 32767) value = 32767;
            if (value < -32768) value = -32768;
            // Keep offering back to back during the long output hold.
            paced_sample(SAMPLE_W'(value), long_hold && n < 16);
            seg_left--;
        end
    endtask

    // Main stimulus.
    initial
    begin
        logic signed [SAMPLE_W-1:0] directed [$];

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        sample      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes while filling, negative truncation,
        // then two constant windows that must settle with a zero limit.
        write_limit('0);
        directed = '{16'sd0, -16'sd32768, 16'sd32767, -16'sd1, 16'sd1, -16'sd7};
        repeat (WIN_LEN) directed.push_back(16'sd32767);
        repeat (WIN_LEN) directed.push_back(-16'sd32768);
        directed.push_back(16'sh5555);
        directed.push_back(16'shAAAA);
        foreach (directed[i])
            paced_sample(directed[i], 1'b0);

        // Random phases over a spread of settle limits.
        run_phase(16'hFFFF, 1'b1);
        run_phase(16'h0000, 1'b0);
        run_phase(16'd5, 1'b0);
        run_phase(16'd60, 1'b0);
        run_phase(16'd900, 1'b1);
        run_phase(LIMIT_W'($urandom), 1'b0);

        // Let the last results come out, then watch for strays.
        in_valid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && sb.pending() != 0; c++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Summary: %0d samples under %0d settle limits, %0d results checked, %0d settled.",
                 samples_sent, limits_used, sb.checked, sb.settled_seen);
        $display("Summary: %0d long output holds, %0d mismatches.", holds_done, sb.errors);
        if (sb.errors == 0)
            $display("tb_moving_average_settle_detect passed");
        else
            $display("tb_moving_average_settle_detect failed");
        $finish;
    end

endmodule
